@@ hdl/lmed_pkg.sv @@
package lmed_pkg;

    // register indexes on the configuration port
    localparam int CFG_INDEX_W = 3;
    localparam logic [CFG_INDEX_W-1:0] CFG_UPPER_CH0   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_UPPER_CH1   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_UPPER_CH2   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_UPPER_CH3   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_RECORD_COUNT = 3'd4;

    localparam int UPPER_WORDS      = 4;
    localparam int NUM_CHANNELS_DEF = 4;

    // record word 0 decode
    localparam int          SPECIAL_BIT = 15;
    localparam logic [15:0] END_MARK    = 16'h8000;

    typedef struct packed {
        logic        first_record;
        logic [15:0] word0;
        logic [15:0] word1;
        logic [15:0] word2;
    } lmed_rec_t;

    typedef struct packed {
        logic [1:0]  channel;
        logic [12:0] energy_bin;
        logic [63:0] timestamp;
    } lmed_evt_t;

    typedef struct packed {
        logic [UPPER_WORDS-1:0][31:0] upper_time;
        logic [15:0]                  record_count;
    } lmed_cfg_t;

    typedef struct packed {
        logic      valid;
        lmed_rec_t rec;
    } lmed_stage_t;

endpackage

@@ hdl/lmed_cfg.sv @@
module lmed_cfg
    import lmed_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   wr_en,
    input  logic [CFG_INDEX_W-1:0] wr_index,
    input  logic [31:0]            wr_data,
    output lmed_cfg_t              cfg
);

    logic [UPPER_WORDS-1:0][31:0] upper_reg;
    logic [UPPER_WORDS-1:0][31:0] upper_next;
    logic [15:0]                  count_reg;
    logic [15:0]                  count_next;

    always_comb
    begin
        upper_next = upper_reg;
        count_next = count_reg;
        if (wr_en)
        begin
            case (wr_index)
                CFG_UPPER_CH0:    upper_next[0] = wr_data;
                CFG_UPPER_CH1:    upper_next[1] = wr_data;
                CFG_UPPER_CH2:    upper_next[2] = wr_data;
                CFG_UPPER_CH3:    upper_next[3] = wr_data;
                CFG_RECORD_COUNT: count_next    = wr_data[15:0];
                default:          ; // unknown index is ignored
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upper_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            upper_reg <= upper_next;
            count_reg <= count_next;
        end
    end

    assign cfg.upper_time   = upper_reg;
    assign cfg.record_count = count_reg;

endmodule

@@ hdl/lmed_in_reg.sv @@
module lmed_in_reg
    import lmed_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        rec_valid,
    output logic        rec_stall,
    input  lmed_rec_t   rec,
    input  logic        advance,
    output lmed_stage_t stage
);

    logic      valid_reg;
    logic      valid_next;
    lmed_rec_t rec_reg;
    logic      load;

    // holds its record only while the core cannot take it
    assign rec_stall  = valid_reg && !advance;
    assign load       = rec_valid && !rec_stall;
    assign valid_next = load || (valid_reg && !advance);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            rec_reg <= rec;
    end

    assign stage.valid = valid_reg;
    assign stage.rec   = rec_reg;

endmodule

@@ hdl/lmed_core.sv @@
module lmed_core
    import lmed_pkg::*;
#(
    parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  lmed_cfg_t   cfg,
    input  lmed_stage_t stage,
    output logic        advance,
    output logic        evt_valid,
    input  logic        evt_stall,
    output lmed_evt_t   evt
);

    logic [UPPER_WORDS-1:0][31:0] upper_reg;
    logic [UPPER_WORDS-1:0][31:0] upper_next;
    logic [UPPER_WORDS-1:0][31:0] upper_eff;
    logic [15:0] seen_reg;
    logic [15:0] seen_next;
    logic [15:0] seen_eff;
    logic        ended_reg;
    logic        ended_next;
    logic        ended_eff;
    logic        evt_valid_reg;
    logic        evt_valid_next;
    lmed_evt_t   evt_reg;
    lmed_evt_t   evt_next;
    logic        take;
    logic        drop;
    logic [15:0] w0;
    logic [3:0]  roll_ch;
    logic        roll_ok;
    logic [1:0]  ev_ch;

    assign advance = !evt_valid_reg || !evt_stall;
    assign take    = stage.valid && advance;
    assign w0      = stage.rec.word0;
    assign roll_ch = w0[3:0];
    assign ev_ch   = w0[14:13];
    assign roll_ok = ({1'b0, roll_ch} < 5'(NUM_CHANNELS))
                  && ({1'b0, roll_ch} < 5'(UPPER_WORDS));

    // a first record reloads the working state before decoding
    assign upper_eff = stage.rec.first_record ? cfg.upper_time : upper_reg;
    assign seen_eff  = stage.rec.first_record ? 16'd0 : seen_reg;
    assign ended_eff = stage.rec.first_record ? 1'b0 : ended_reg;
    assign drop      = ended_eff || (seen_eff >= cfg.record_count);

    always_comb
    begin
        upper_next     = upper_reg;
        seen_next      = seen_reg;
        ended_next     = ended_reg;
        evt_valid_next = evt_valid_reg && evt_stall;
        evt_next       = evt_reg;
        if (take)
        begin
            upper_next = upper_eff;
            seen_next  = seen_eff;
            ended_next = ended_eff;
            if (!drop)
            begin
                seen_next = seen_eff + 16'd1;
                if (w0[SPECIAL_BIT])
                begin
                    if (w0 == END_MARK)
                        ended_next = 1'b1;
                    else if (roll_ok)
                        upper_next[roll_ch[1:0]] = {stage.rec.word2, stage.rec.word1};
                end
                else
                begin
                    evt_valid_next      = 1'b1;
                    evt_next.channel    = ev_ch;
                    evt_next.energy_bin = w0[12:0];
                    // word1 and word2 << 16 never overlap, so the sum is a concatenation
                    evt_next.timestamp  = {upper_eff[ev_ch], stage.rec.word2, stage.rec.word1};
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upper_reg     <= '0;
            seen_reg      <= '0;
            ended_reg     <= 1'b0;
            evt_valid_reg <= 1'b0;
        end
        else
        begin
            upper_reg     <= upper_next;
            seen_reg      <= seen_next;
            ended_reg     <= ended_next;
            evt_valid_reg <= evt_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        evt_reg <= evt_next;
    end

    assign evt_valid = evt_valid_reg;
    assign evt       = evt_reg;

endmodule

@@ hdl/list_mode_event_decoder.sv @@
// list-mode record decoder
//
// record channel: rec_valid / rec_stall / rec, one three-word record per
// transaction, taken at a clock edge with rec_valid high and rec_stall low.
// event channel: evt_valid / evt_stall / evt, one decoded event per
// transaction (channel, 13-bit energy bin, 64-bit timestamp). special
// records, the end marker and records past the count give no transaction.
// config channel: cfg_valid / cfg_ready / cfg_index / cfg_data, always
// ready; indexes 0..3 are the per-channel upper time words, 4 is the record
// count, others are ignored. write config only while the block is idle.
// a record transaction loads the input register, then decode writes the
// result register. throughput: one record per cycle while no event is stalled,
// set by the single decode step between the two registers.
// a stalled event holds; the input register then fills and rec_stall rises
// until the event is taken. reset clears the config, the working state and
// the valid flags, not the record and event data; the record count is then
// zero, so records are dropped until it is written.
module list_mode_event_decoder
    import lmed_pkg::*;
#(
    parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    // record input
    input  logic                   rec_valid,
    output logic                   rec_stall,
    input  lmed_rec_t              rec,
    // decoded events
    output logic                   evt_valid,
    input  logic                   evt_stall,
    output lmed_evt_t              evt,
    // register writes
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [31:0]            cfg_data
);

    lmed_cfg_t   cfg;
    lmed_stage_t stage;
    logic        advance;

    // writes never wait
    assign cfg_ready = 1'b1;

    // config register bank
    lmed_cfg u_cfg
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    // input register
    lmed_in_reg u_in_reg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .rec_valid (rec_valid),
        .rec_stall (rec_stall),
        .rec       (rec),
        .advance   (advance),
        .stage     (stage)
    );

    // decode, working state and result register
    lmed_core #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_core
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .stage     (stage),
        .advance   (advance),
        .evt_valid (evt_valid),
        .evt_stall (evt_stall),
        .evt       (evt)
    );

endmodule

@@ hdl/lmed_chk.sv @@
module lmed_chk
    import lmed_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      rec_valid,
    input logic      rec_stall,
    input lmed_rec_t rec,
    input logic      evt_valid,
    input logic      evt_stall,
    input lmed_evt_t evt
);

    // stalled event holds
    a_evt_hold: assert property (@(posedge clk) disable iff (!rst_n)
        evt_valid && evt_stall |=> evt_valid && $stable(evt))
        else $error("stalled event changed");

    // empty result register means the input never stalls
    a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !evt_valid |-> !rec_stall)
        else $error("record stalled with empty result register");

    // a fresh event comes from a record transaction through the input register
    a_evt_origin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(evt_valid) |-> $past(rec_valid && !rec_stall, 2))
        else $error("event without a record transaction");

    // low time bits and bin pass straight through
    a_evt_fields: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(evt_valid) |->
            (evt.timestamp[31:0] == {$past(rec.word2, 2), $past(rec.word1, 2)})
            && (evt.energy_bin == $past(rec.word0[12:0], 2)))
        else $error("event fields do not match record");

endmodule

bind list_mode_event_decoder lmed_chk u_lmed_chk
(
    .clk       (clk),
    .rst_n     (rst_n),
    .rec_valid (rec_valid),
    .rec_stall (rec_stall),
    .rec       (rec),
    .evt_valid (evt_valid),
    .evt_stall (evt_stall),
    .evt       (evt)
);

@@ tb/tb_list_mode_event_decoder.sv @@
module tb_list_mode_event_decoder;
    import lmed_pkg::*;

    localparam int CLK_HALF     = 6;
    localparam int RESET_CYCLES = 9;
    localparam int DRAIN_CYCLES = 8;       // two-stage pipe plus margin
    localparam int HOLD_CYCLES  = 300;     // long output back-pressure stretch
    localparam int LIMIT_CYCLES = 400000;
    localparam int MAX_REPORTS  = 10;

    // register indexes in the order a full load writes them
    localparam logic [CFG_INDEX_W-1:0] LOAD_ORDER [5] = '{
        CFG_UPPER_CH0, CFG_UPPER_CH1, CFG_UPPER_CH2, CFG_UPPER_CH3, CFG_RECORD_COUNT
    };

    // dut ports, inputs all known from time zero
    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   rec_valid = 1'b0;
    logic                   rec_stall;
    lmed_rec_t              rec       = '0;
    logic                   evt_valid;
    logic                   evt_stall = 1'b0;
    lmed_evt_t              evt;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [31:0]            cfg_data  = '0;

    // records waiting for the driver, events waiting for the monitor
    lmed_rec_t pending_records [$];
    lmed_evt_t expected_events [$];

    // register shadow, as last written over the config channel
    logic [31:0] reg_upper [UPPER_WORDS];
    logic [15:0] reg_count;

    // working state of the decode, as the block should hold it
    logic [31:0] live_upper [UPPER_WORDS];
    logic [15:0] live_seen;
    logic        live_ended;

    // traffic shaping
    int   idle_pct  = 0;
    int   stall_pct = 0;
    logic hold_go   = 1'b0;
    int   hold_left = 0;

    // bookkeeping
    int errors         = 0;
    int records_sent   = 0;
    int events_checked = 0;
    int buffers_queued = 0;
    int reg_writes     = 0;
    int cycles         = 0;

    list_mode_event_decoder i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .rec_valid (rec_valid),
        .rec_stall (rec_stall),
        .rec       (rec),
        .evt_valid (evt_valid),
        .evt_stall (evt_stall),
        .evt       (evt),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #CLK_HALF clk = ~clk;
    end

    // ------------------------------------------------------------------
    // decode predictor: applies one accepted record to the working state
    // and queues the event it should produce, if any
    // ------------------------------------------------------------------
    function automatic void decode_record(input lmed_rec_t r);
        lmed_evt_t  e;
        logic [1:0] ch;
        logic [3:0] roll_ch;
        // a first record reloads the header words and restarts the buffer
        if (r.first_record)
        begin
            live_upper = reg_upper;
            live_seen  = '0;
            live_ended = 1'b0;
        end
        // past the end marker or out of budget: dropped, not counted
        if (live_ended || live_seen >= reg_count)
            return;
        live_seen = live_seen + 16'd1;
        if (r.word0[SPECIAL_BIT])
        begin
            if (r.word0 == END_MARK)
                live_ended = 1'b1;
            else
            begin
                // rollover: channels past the table are skipped silently
                roll_ch = r.word0[3:0];
                if (roll_ch < NUM_CHANNELS_DEF)
                    live_upper[roll_ch[1:0]] = {r.word2, r.word1};
            end
            return;
        end
        ch           = r.word0[14:13];
        e.channel    = ch;
        e.energy_bin = r.word0[12:0];
        // word1 + (word2 << 16) never overlaps the upper word: plain concat
        e.timestamp  = {live_upper[ch], r.word2, r.word1};
        expected_events.push_back(e);
    endfunction

    // ------------------------------------------------------------------
    // record builders
    // ------------------------------------------------------------------
    function automatic lmed_rec_t event_record(input logic first, input logic [1:0] ch,
                                               input logic [12:0] bin,
                                               input logic [15:0] lo, input logic [15:0] mid);
        lmed_rec_t r;
        r.first_record = first;
        r.word0        = {1'b0, ch, bin};
        r.word1        = lo;
        r.word2        = mid;
        return r;
    endfunction

    function automatic lmed_rec_t rollover_record(input logic first, input logic [3:0] ch,
                                                  input logic [31:0] upper);
        lmed_rec_t r;
        r.first_record = first;
        r.word0        = {1'b1, 11'($urandom), ch};
        // all-zero filler on channel 0 would read as the end marker
        if (r.word0 == END_MARK)
            r.word0[4] = 1'b1;
        r.word1 = upper[15:0];
        r.word2 = upper[31:16];
        return r;
    endfunction

    function automatic lmed_rec_t end_record(input logic first);
        lmed_rec_t r;
        r.first_record = first;
        r.word0        = END_MARK;
        r.word1        = 16'($urandom);
        r.word2        = 16'($urandom);
        return r;
    endfunction

    // mostly events, some rollovers (a few out of range), rare end markers,
    // and a slice of fully random words
    function automatic lmed_rec_t random_record(input logic first);
        int        pick;
        lmed_rec_t r;
        pick = $urandom_range(99);
        if (pick < 68)
            r = event_record(first, 2'($urandom), 13'($urandom), 16'($urandom), 16'($urandom));
        else if (pick < 80)
            r = rollover_record(first, 4'($urandom_range(NUM_CHANNELS_DEF - 1)), $urandom);
        else if (pick < 85)
            r = rollover_record(first, 4'($urandom_range(15, NUM_CHANNELS_DEF)), $urandom);
        else if (pick < 88)
            r = end_record(first);
        else
        begin
            r.first_record = first;
            r.word0        = 16'($urandom);
            r.word1        = 16'($urandom);
            r.word2        = 16'($urandom);
        end
        return r;
    endfunction

    // one buffer: usually opened by a first record, sometimes longer than
    // the budget, now and then restarted midway; returns its length
    function automatic int queue_buffer();
        int len;
        int max_len;
        max_len = (reg_count < 16'd44) ? int'(reg_count) + 4 : 48;
        len     = $urandom_range(max_len, 1);
        pending_records.push_back(random_record($urandom_range(9) != 0));
        for (int k = 1; k < len; k++)
            pending_records.push_back(random_record($urandom_range(39) == 0));
        buffers_queued++;
        return len;
    endfunction

    // ------------------------------------------------------------------
    // stimulus-side tasks
    // ------------------------------------------------------------------
    // wait until every record is in, every event is out, and the pipe is empty
    task automatic wait_idle();
        do
            @(posedge clk);
        while (pending_records.size() != 0 || rec_valid || expected_events.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // full register load plus one write to an unused index
    task automatic load_regs(input logic [31:0] u0, input logic [31:0] u1,
                             input logic [31:0] u2, input logic [31:0] u3,
                             input logic [15:0] cnt);
        logic [31:0]            vals [5];
        logic [CFG_INDEX_W-1:0] idx;
        logic [31:0]            data;
        vals = '{u0, u1, u2, u3, {16'h0000, cnt}};
        for (int k = 0; k <= 5; k++)
        begin
            if (k < 5)
            begin
                idx  = LOAD_ORDER[k];
                data = vals[k];
            end
            else
            begin
                idx  = CFG_RECORD_COUNT + CFG_INDEX_W'($urandom_range(3, 1));
                data = $urandom;
            end
            cfg_valid <= 1'b1;
            cfg_index <= idx;
            cfg_data  <= data;
            do
                @(posedge clk);
            while (!cfg_ready);
            // write landed at this edge
            if (idx == CFG_RECORD_COUNT)
                reg_count = data[15:0];
            else if (idx <= CFG_UPPER_CH3)
                reg_upper[idx[1:0]] = data;
            reg_writes++;
        end
        cfg_valid <= 1'b0;
    endtask

    // random buffers under one traffic mix, optionally with a long output hold
    task automatic run_phase(input int idle, input int stall, input int n, input logic hold);
        int queued;
        queued = 0;
        idle_pct  <= idle;
        stall_pct <= stall;
        while (queued < n)
            queued += queue_buffer();
        if (hold)
        begin
            hold_go <= 1'b1;
            @(posedge clk);
            hold_go <= 1'b0;
        end
        wait_idle();
    endtask

    // ------------------------------------------------------------------
    // record driver: offers the next pending record, holds it while stalled,
    // predicts its outcome once the transaction completes
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rec_valid <= 1'b0;
            rec       <= '0;
        end
        else
        begin
            if (rec_valid && !rec_stall)
            begin
                decode_record(rec);
                records_sent++;
            end
            // free to change only when nothing is held
            if (!rec_valid || !rec_stall)
            begin
                if (pending_records.size() != 0 && $urandom_range(99) >= idle_pct)
                begin
                    rec       <= pending_records.pop_front();
                    rec_valid <= 1'b1;
                end
                else
                    rec_valid <= 1'b0;
            end
        end
    end

    // long hold-off counter for the pressure phase
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hold_left <= 0;
        else if (hold_go)
            hold_left <= HOLD_CYCLES;
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    // ------------------------------------------------------------------
    // event monitor: checks each completed transaction against the oldest
    // expected event, then picks the next stall value
    // ------------------------------------------------------------------
    task automatic note_mismatch(input string what, input logic [63:0] want,
                                 input logic [63:0] got);
        errors++;
        if (errors <= MAX_REPORTS)
            $display("mismatch in %s at cycle %0d: expected %h, got %h",
                     what, cycles, want, got);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        lmed_evt_t want;
        if (!rst_n)
            evt_stall <= 1'b0;
        else
        begin
            if (evt_valid && !evt_stall)
            begin
                events_checked++;
                if (expected_events.size() == 0)
                    note_mismatch("event with none expected", '0, evt.timestamp);
                else
                begin
                    want = expected_events.pop_front();
                    if (evt.channel !== want.channel)
                        note_mismatch("channel", 64'(want.channel), 64'(evt.channel));
                    if (evt.energy_bin !== want.energy_bin)
                        note_mismatch("energy_bin", 64'(want.energy_bin),
                                      64'(evt.energy_bin));
                    if (evt.timestamp !== want.timestamp)
                        note_mismatch("timestamp", want.timestamp, evt.timestamp);
                end
            end
            evt_stall <= (hold_left != 0) || ($urandom_range(99) < stall_pct);
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("timeout after %0d cycles, %0d events still expected",
                     cycles, expected_events.size());
            $display("Some tests failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------
    initial
    begin
        for (int k = 0; k < UPPER_WORDS; k++)
        begin
            reg_upper[k]  = '0;
            live_upper[k] = '0;
        end
        reg_count  = '0;
        live_seen  = '0;
        live_ended = 1'b0;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // count is zero out of reset: everything here is dropped
        pending_records.push_back(event_record(1'b1, 2'd1, 13'h00AB, 16'h1234, 16'h5678));
        pending_records.push_back(event_record(1'b0, 2'd2, 13'h1FFF, 16'hFFFF, 16'hFFFF));
        wait_idle();

        // directed buffer: extreme header words, every record kind
        load_regs(32'h0000_0000, 32'hFFFF_FFFF, 32'h1234_5678, 32'h8000_0001, 16'd20);
        pending_records.push_back(event_record(1'b1, 2'd0, 13'h0000, 16'h0000, 16'h0000));
        pending_records.push_back(event_record(1'b0, 2'd1, 13'h1FFF, 16'hFFFF, 16'hFFFF));
        pending_records.push_back(event_record(1'b0, 2'd2, 13'h0AAA, 16'h5555, 16'hAAAA));
        pending_records.push_back(event_record(1'b0, 2'd3, 13'h1555, 16'hAAAA, 16'h5555));
        pending_records.push_back(rollover_record(1'b0, 4'd2, 32'hDEAD_BEEF));
        pending_records.push_back(event_record(1'b0, 2'd2, 13'h0123, 16'h8001, 16'h7FFE));
        // rollovers naming channels past the table leave every word alone
        pending_records.push_back(rollover_record(1'b0, 4'd5, 32'h1111_1111));
        pending_records.push_back(rollover_record(1'b0, 4'd15, 32'h2222_2222));
        pending_records.push_back(event_record(1'b0, 2'd1, 13'h0FFF, 16'h0001, 16'h8000));
        pending_records.push_back(rollover_record(1'b0, 4'd0, 32'hFFFF_FFFF));
        pending_records.push_back(event_record(1'b0, 2'd0, 13'h1000, 16'hFFFF, 16'hFFFF));
        // end marker, then a record that must be dropped
        pending_records.push_back(end_record(1'b0));
        pending_records.push_back(event_record(1'b0, 2'd3, 13'h0042, 16'h4242, 16'h4242));
        // a new first record reloads the header words
        pending_records.push_back(event_record(1'b1, 2'd2, 13'h0777, 16'h0F0F, 16'hF0F0));
        // end marker as the very first record
        pending_records.push_back(end_record(1'b1));
        pending_records.push_back(event_record(1'b0, 2'd1, 13'h0001, 16'h0002, 16'h0003));
        wait_idle();

        // budget of three: the fourth record is dropped
        load_regs(32'hA5A5_A5A5, 32'h5A5A_5A5A, 32'h0000_0001, 32'hFFFF_FFFE, 16'd3);
        pending_records.push_back(event_record(1'b1, 2'd3, 13'h1ABC, 16'hC0DE, 16'hBEEF));
        pending_records.push_back(event_record(1'b0, 2'd0, 13'h0ABC, 16'h0001, 16'h0000));
        pending_records.push_back(rollover_record(1'b0, 4'd3, 32'h0000_0000));
        pending_records.push_back(event_record(1'b0, 2'd3, 13'h1111, 16'h2222, 16'h3333));
        wait_idle();

        // zero budget: nothing decodes even after a first record
        load_regs($urandom, $urandom, $urandom, $urandom, 16'd0);
        pending_records.push_back(event_record(1'b1, 2'd0, 13'h0055, 16'h0066, 16'h0077));
        pending_records.push_back(end_record(1'b0));
        wait_idle();

        // random buffers under the four traffic mixes
        load_regs($urandom, $urandom, $urandom, $urandom, 16'($urandom_range(48, 8)));
        run_phase(0, 0, 140, 1'b0);
        load_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
        run_phase(62, 0, 140, 1'b0);
        load_regs(32'h0, 32'h0, 32'h0, 32'h0, 16'($urandom_range(30, 1)));
        run_phase(0, 62, 140, 1'b0);
        load_regs($urandom, $urandom, $urandom, $urandom, 16'($urandom_range(60, 2)));
        run_phase(26, 26, 140, 1'b0);

        // back-pressure: output held for a long stretch while input keeps coming
        load_regs($urandom, $urandom, $urandom, $urandom, 16'hFFFF);
        run_phase(0, 0, 120, 1'b1);

        // budget of one: only records carrying the first-record flag decode
        load_regs($urandom, $urandom, $urandom, $urandom, 16'd1);
        run_phase(0, 0, 40, 1'b0);

        $display("covered %0d records in %0d random buffers plus directed cases, %0d events checked",
                 records_sent, buffers_queued, events_checked);
        $display("%0d register writes; traffic: free-running, sender gaps, output stalls, both, long hold",
                 reg_writes);
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
